/* hw/rtl/macd_pkg.sv */
// Shared types, constants and helpers for the MACD crossover block.
package macd_pkg;

    localparam int PRICE_W  = 32;
    localparam int WEIGHT_W = 17;
    localparam int FRAC_W   = 16;
    localparam int AVG_W    = 48;
    localparam int LINE_W   = 49;
    localparam int DIFF_W   = 50;
    localparam int CFG_IDX_W = 2;

    localparam logic [WEIGHT_W-1:0] ONE_Q16          = 17'd65536;
    localparam logic [WEIGHT_W-1:0] FAST_WEIGHT_RST  = 17'd10082;
    localparam logic [WEIGHT_W-1:0] SLOW_WEIGHT_RST  = 17'd4855;
    localparam logic [WEIGHT_W-1:0] LINE_WEIGHT_RST  = 17'd13107;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WEIGHT = 2'd2;

    // Result signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_BUY  = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIFF,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_UPD,
        OP_MACD,
        OP_FIN,
        OP_SKIP
    } op_t;

    typedef enum logic [1:0] {
        SEL_FAST,
        SEL_SLOW,
        SEL_LINE
    } sel_t;

    typedef struct packed {
        logic load_in;
        op_t  op;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic price_zero;
        logic primed;
    } status_t;

    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] w);
        clamp_weight = (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

endpackage

/* hw/rtl/macd_mul.sv */
// Shared registered signed multiplier, 33 x 18 bits.
module macd_mul (
    input  logic                clk,
    input  logic                en,
    input  logic signed [32:0]  a,
    input  logic signed [17:0]  b,
    output logic signed [50:0]  p
);

    logic signed [50:0] p_reg;
    logic signed [50:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* hw/rtl/macd_dp.sv */
// Datapath: weights, averages, lines, blend arithmetic and the result register.
module macd_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  macd_pkg::cmd_t                         cmd,
    output macd_pkg::status_t                      status,
    input  logic [macd_pkg::PRICE_W-1:0]           price,
    input  logic                                   cfg_write,
    input  logic [macd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [macd_pkg::WEIGHT_W-1:0]          cfg_data,
    output logic [1:0]                             signal,
    output logic signed [macd_pkg::DIFF_W-1:0]     strength
);

    logic [macd_pkg::WEIGHT_W-1:0]        fast_weight_reg;
    logic [macd_pkg::WEIGHT_W-1:0]        slow_weight_reg;
    logic [macd_pkg::WEIGHT_W-1:0]        line_weight_reg;
    logic [macd_pkg::AVG_W-1:0]           fast_reg;
    logic [macd_pkg::AVG_W-1:0]           slow_reg;
    logic signed [macd_pkg::LINE_W-1:0]   macd_reg;
    logic signed [macd_pkg::LINE_W-1:0]   sig_line_reg;
    logic                                 holding_reg;
    logic                                 primed_reg;

    logic [macd_pkg::PRICE_W-1:0]         price_reg;
    logic                                 prev_above_reg;
    logic signed [macd_pkg::LINE_W-1:0]   macd_new_reg;
    logic signed [macd_pkg::DIFF_W-1:0]   diff_reg;
    logic [48:0]                          acc_reg;
    logic [1:0]                           signal_reg;
    logic signed [macd_pkg::DIFF_W-1:0]   strength_reg;

    logic signed [macd_pkg::DIFF_W-1:0]   old_val;
    logic signed [macd_pkg::DIFF_W-1:0]   x_val;
    logic [macd_pkg::WEIGHT_W-1:0]        w_sel;
    logic                                 mul_en;
    logic signed [32:0]                   mul_a;
    logic signed [17:0]                   mul_b;
    logic signed [50:0]                   mul_p;
    logic signed [51:0]                   upd;
    logic signed [macd_pkg::DIFF_W-1:0]   fin_diff;
    logic                                 fin_above;
    logic [1:0]                           fin_sig;
    logic                                 holding_next;

    // Operand selection for the blend in progress
    always_comb
    begin
        unique case (cmd.sel)
            macd_pkg::SEL_FAST:
            begin
                old_val = $signed({2'b00, fast_reg});
                x_val   = $signed({2'b00, price_reg, 16'h0000});
                w_sel   = macd_pkg::clamp_weight(fast_weight_reg);
            end
            macd_pkg::SEL_SLOW:
            begin
                old_val = $signed({2'b00, slow_reg});
                x_val   = $signed({2'b00, price_reg, 16'h0000});
                w_sel   = macd_pkg::clamp_weight(slow_weight_reg);
            end
            macd_pkg::SEL_LINE:
            begin
                old_val = $signed({sig_line_reg[macd_pkg::LINE_W-1], sig_line_reg});
                x_val   = $signed({macd_new_reg[macd_pkg::LINE_W-1], macd_new_reg});
                w_sel   = macd_pkg::clamp_weight(line_weight_reg);
            end
            default:
            begin
                old_val = '0;
                x_val   = '0;
                w_sel   = '0;
            end
        endcase
    end

    // Difference times weight in two partial products: low 32 bits, then signed top bits
    assign mul_en = (cmd.op == macd_pkg::OP_MUL_LO) || (cmd.op == macd_pkg::OP_MUL_HI);
    assign mul_a  = (cmd.op == macd_pkg::OP_MUL_HI)
                  ? $signed({{15{diff_reg[macd_pkg::DIFF_W-1]}}, diff_reg[49:32]})
                  : $signed({1'b0, diff_reg[31:0]});
    assign mul_b  = $signed({1'b0, w_sel});

    macd_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // old + floor(d*w / 2^16); the high product carries no bits below 2^32
    assign upd = $signed({{2{old_val[macd_pkg::DIFF_W-1]}}, old_val})
               + $signed({19'b0, acc_reg[48:16]})
               + $signed({mul_p[35:0], 16'h0000});

    assign fin_diff  = $signed({macd_new_reg[macd_pkg::LINE_W-1], macd_new_reg})
                     - $signed({sig_line_reg[macd_pkg::LINE_W-1], sig_line_reg});
    assign fin_above = macd_new_reg > sig_line_reg;

    always_comb
    begin
        fin_sig      = macd_pkg::SIG_NONE;
        holding_next = holding_reg;
        priority if (fin_above && !prev_above_reg && !holding_reg)
        begin
            fin_sig      = macd_pkg::SIG_BUY;
            holding_next = 1'b1;
        end
        else if (!fin_above && prev_above_reg && holding_reg)
        begin
            fin_sig      = macd_pkg::SIG_SELL;
            holding_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_weight_reg <= macd_pkg::FAST_WEIGHT_RST;
            slow_weight_reg <= macd_pkg::SLOW_WEIGHT_RST;
            line_weight_reg <= macd_pkg::LINE_WEIGHT_RST;
            fast_reg        <= '0;
            slow_reg        <= '0;
            macd_reg        <= '0;
            sig_line_reg    <= '0;
            holding_reg     <= 1'b0;
            primed_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == macd_pkg::CFG_FAST_WEIGHT)
                begin
                    fast_weight_reg <= cfg_data;
                end
                if (cfg_index == macd_pkg::CFG_SLOW_WEIGHT)
                begin
                    slow_weight_reg <= cfg_data;
                end
                if (cfg_index == macd_pkg::CFG_LINE_WEIGHT)
                begin
                    line_weight_reg <= cfg_data;
                end
            end
            if (cmd.op == macd_pkg::OP_UPD)
            begin
                unique case (cmd.sel)
                    macd_pkg::SEL_FAST: fast_reg     <= upd[macd_pkg::AVG_W-1:0];
                    macd_pkg::SEL_SLOW: slow_reg     <= upd[macd_pkg::AVG_W-1:0];
                    macd_pkg::SEL_LINE: sig_line_reg <= upd[macd_pkg::LINE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == macd_pkg::OP_FIN)
            begin
                macd_reg    <= macd_new_reg;
                holding_reg <= holding_next;
            end
            // Seed on the first nonzero price
            if (cmd.op == macd_pkg::OP_SKIP && price_reg != '0)
            begin
                fast_reg     <= {price_reg, 16'h0000};
                slow_reg     <= {price_reg, 16'h0000};
                macd_reg     <= '0;
                sig_line_reg <= '0;
                primed_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            price_reg      <= price;
            prev_above_reg <= macd_reg > sig_line_reg;
        end
        unique case (cmd.op)
            macd_pkg::OP_DIFF:   diff_reg <= x_val - old_val;
            macd_pkg::OP_MUL_HI: acc_reg  <= mul_p[48:0];
            macd_pkg::OP_MACD:
            begin
                macd_new_reg <= $signed({1'b0, fast_reg}) - $signed({1'b0, slow_reg});
            end
            macd_pkg::OP_FIN:
            begin
                signal_reg   <= fin_sig;
                strength_reg <= fin_diff;
            end
            macd_pkg::OP_SKIP:
            begin
                signal_reg   <= macd_pkg::SIG_NONE;
                strength_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign status.price_zero = (price == '0);
    assign status.primed     = primed_reg;
    assign signal            = signal_reg;
    assign strength          = strength_reg;

endmodule

/* hw/rtl/macd_ctrl.sv */
// Controller: sequences the three blends and the input and result handshakes.
module macd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  macd_pkg::status_t  status,
    output macd_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_LO,
        ST_HI,
        ST_UPD,
        ST_MACD,
        ST_FIN,
        ST_SKIP
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    macd_pkg::sel_t  sel_reg;
    macd_pkg::sel_t  sel_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.load_in    = 1'b0;
        cmd.op         = macd_pkg::OP_NONE;
        cmd.sel        = sel_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    sel_next    = macd_pkg::SEL_FAST;
                    if (status.price_zero || !status.primed)
                    begin
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF:
            begin
                cmd.op     = macd_pkg::OP_DIFF;
                state_next = ST_LO;
            end
            ST_LO:
            begin
                cmd.op     = macd_pkg::OP_MUL_LO;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                cmd.op     = macd_pkg::OP_MUL_HI;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.op = macd_pkg::OP_UPD;
                unique case (sel_reg)
                    macd_pkg::SEL_FAST:
                    begin
                        sel_next   = macd_pkg::SEL_SLOW;
                        state_next = ST_DIFF;
                    end
                    macd_pkg::SEL_SLOW: state_next = ST_MACD;
                    macd_pkg::SEL_LINE: state_next = ST_FIN;
                    default:            state_next = ST_IDLE;
                endcase
            end
            ST_MACD:
            begin
                cmd.op     = macd_pkg::OP_MACD;
                sel_next   = macd_pkg::SEL_LINE;
                state_next = ST_DIFF;
            end
            ST_FIN:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    cmd.op         = macd_pkg::OP_FIN;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SKIP:
            begin
                if (out_free)
                begin
                    cmd.op         = macd_pkg::OP_SKIP;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= macd_pkg::SEL_FAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/macd_crossover_signal.sv */
// Top level of the MACD crossover signal block.
//
//  channel   direction  handshake            payload
//  in        into       in_valid/in_ready    price[31:0]
//  out       out of     out_valid/out_ready  signal[1:0], strength[49:0] signed
//  cfg       into       cfg_write            cfg_index[1:0], cfg_data[16:0]
//
// A nonzero price after the first runs from acceptance to a valid result as follows:
// fast, slow and signal-line blends run one after another through one 33x18 multiplier,
// each in four steps (difference, low product, high product, update), plus MACD and finish.
// A zero price or the first nonzero price goes from acceptance through the skip step to its result.
// Reset clears averages, lines and flags and returns the weights to their defaults.
// A result waiting on out_ready holds; the next item is taken meanwhile and its last step
// waits until the result register frees.
module macd_crossover_signal (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [macd_pkg::PRICE_W-1:0]          price,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            signal,
    output logic signed [macd_pkg::DIFF_W-1:0]    strength,
    input  logic                                  cfg_write,
    input  logic [macd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [macd_pkg::WEIGHT_W-1:0]         cfg_data
);

    macd_pkg::cmd_t     cmd;
    macd_pkg::status_t  status;

    macd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    macd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .price     (price),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .signal    (signal),
        .strength  (strength)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the block busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on the cycle after an accepted item");

    // a buy needs MACD strictly above the signal line
    a_buy_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && signal == macd_pkg::SIG_BUY |-> !strength[macd_pkg::DIFF_W-1]
            && strength != '0)
        else $error("buy result with non-positive strength");

    // a sell needs MACD at or below the signal line
    a_sell_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && signal == macd_pkg::SIG_SELL |-> strength[macd_pkg::DIFF_W-1]
            || strength == '0)
        else $error("sell result with positive strength");
`endif

endmodule
